// ===== rtl/pswf_pkg.sv =====
// ============================================================================
// pswf_pkg - shared types for the per-stream replay window filter
// Transaction payloads, verdict codes, the cell command bundle and
// default sizes used by the top level and by the recency cells.
// ============================================================================
package pswf_pkg;

    localparam int unsigned MAX_STREAMS_DEF = 8;
    localparam int unsigned WINDOW_BITS_DEF = 128;
    localparam int unsigned SID_W           = 32;
    localparam int unsigned IDX_W           = 48;

    typedef enum logic [1:0] {
        VERDICT_FRESH = 2'd0,
        VERDICT_DUP   = 2'd1,
        VERDICT_OLD   = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [SID_W-1:0] stream_id;
        logic [IDX_W-1:0] pkt_index;
    } req_t;

    typedef struct packed {
        verdict_t verdict;
        logic     evicted;
    } rsp_t;

    // compare: look up the held stream id; update: load from the neighbor
    typedef struct packed {
        logic compare;
        logic update;
    } cell_cmd_t;

endpackage

// ===== rtl/per_stream_replay_window_filter_top.sv =====
// ============================================================================
// per_stream_replay_window_filter_top - per-stream anti-replay filter
// Keeps a table of streams, each with a highest packet index and a sliding
// seen-window, and judges every packet as fresh, duplicate or too old.
// ============================================================================
//
//  channel   | ports                      | handshake
//  ----------+----------------------------+------------------------------------
//  request   | start, busy, request       | taken on a clock edge with start=1,
//            |                            | busy=0
//  result    | done, result               | one cycle strobe, always taken
//
//  Each transaction runs through lookup in all cells, selection of the hit
//  entry with the index subtract, then window update and write-back through
//  the cell row. busy is low in the write-back cycle, so a new transaction
//  can be taken while the previous one writes back.
//  Reset (rst_n low, asynchronous) empties the table at once; no clearing pass.
//  The result is registered and appears in the cycle after write-back; the receiver cannot stall it.
//
//  The table is a row of cells kept in most-recent-first order: every access
//  moves the entry to the front and pushes the cells in front of it back by
//  one, so the least recently used entry is always the last one. A miss pushes
//  the whole row and drops the last cell, which is an eviction when it held a
//  stream. Empty cells always sit at the tail, so a free cell is used first.
// ============================================================================
module per_stream_replay_window_filter_top #(
    parameter int unsigned MAX_STREAMS = pswf_pkg::MAX_STREAMS_DEF,
    parameter int unsigned WINDOW_BITS = pswf_pkg::WINDOW_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  pswf_pkg::req_t request,
    output logic           busy,
    output logic           done,
    output pswf_pkg::rsp_t result
);

    localparam int unsigned SHIFT_W = $clog2(WINDOW_BITS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SELECT,
        ST_UPDATE
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic                       accept;
    pswf_pkg::req_t             req_reg;
    pswf_pkg::cell_cmd_t        cell_cmd;
    pswf_pkg::rsp_t             result_reg;
    logic                       done_reg;

    // cell row
    logic [MAX_STREAMS:0]       chain_hit;
    logic [MAX_STREAMS-1:0]     hit_vec;
    logic [MAX_STREAMS-1:0]     valid_vec;
    logic [pswf_pkg::SID_W-1:0] cell_sid     [MAX_STREAMS];
    logic [pswf_pkg::IDX_W-1:0] cell_highest [MAX_STREAMS];
    logic [WINDOW_BITS-1:0]     cell_window  [MAX_STREAMS];

    // selection stage
    logic [pswf_pkg::IDX_W-1:0] sel_highest;
    logic [WINDOW_BITS-1:0]     sel_window;
    logic                       sel_gt;
    logic [pswf_pkg::IDX_W-1:0] sel_dist;

    logic                       miss_reg;
    logic                       evict_reg;
    logic                       gt_reg;
    logic [pswf_pkg::IDX_W-1:0] dist_reg;
    logic [pswf_pkg::IDX_W-1:0] highest_reg;
    logic [WINDOW_BITS-1:0]     window_reg;

    // update stage
    logic                       far;
    logic [SHIFT_W-1:0]         shamt;
    logic [WINDOW_BITS-1:0]     bit_mask;
    logic [pswf_pkg::IDX_W-1:0] highest_next;
    logic [WINDOW_BITS-1:0]     window_next;
    pswf_pkg::verdict_t         verdict_next;

    assign busy   = (state_reg == ST_LOOKUP) || (state_reg == ST_SELECT);
    assign accept = start && !busy;

    assign cell_cmd.compare = (state_reg == ST_LOOKUP);
    assign cell_cmd.update  = (state_reg == ST_UPDATE);

    // ------------------------------------------------------------------------
    // Cell row: cell 0 is the most recent entry and loads the updated entry
    // on every write-back; each later cell takes its front neighbor's entry unless the hit lies in front of it.
    // ------------------------------------------------------------------------
    assign chain_hit[0] = 1'b0;

    for (genvar k = 0; k < MAX_STREAMS; k++)
    begin : g_cell
        logic                       prev_valid;
        logic [pswf_pkg::SID_W-1:0] prev_sid;
        logic [pswf_pkg::IDX_W-1:0] prev_highest;
        logic [WINDOW_BITS-1:0]     prev_window;

        if (k == 0)
        begin : g_front
            assign prev_valid   = 1'b1;
            assign prev_sid     = req_reg.stream_id;
            assign prev_highest = highest_next;
            assign prev_window  = window_next;
        end
        else
        begin : g_rest
            assign prev_valid   = valid_vec[k-1];
            assign prev_sid     = cell_sid[k-1];
            assign prev_highest = cell_highest[k-1];
            assign prev_window  = cell_window[k-1];
        end

        pswf_cell #(
            .WINDOW_BITS (WINDOW_BITS)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .cmd           (cell_cmd),
            .key           (req_reg.stream_id),
            .chain_hit_in  (chain_hit[k]),
            .chain_hit_out (chain_hit[k+1]),
            .prev_valid    (prev_valid),
            .prev_sid      (prev_sid),
            .prev_highest  (prev_highest),
            .prev_window   (prev_window),
            .valid         (valid_vec[k]),
            .sid           (cell_sid[k]),
            .highest       (cell_highest[k]),
            .window        (cell_window[k]),
            .hit           (hit_vec[k])
        );
    end

    // ------------------------------------------------------------------------
    // Selection: pick the hit entry (at most one) and measure the index jump.
    // ------------------------------------------------------------------------
    always_comb
    begin
        sel_highest = '0;
        sel_window  = '0;
        for (int k = 0; k < MAX_STREAMS; k++)
        begin
            sel_highest = sel_highest | ({pswf_pkg::IDX_W{hit_vec[k]}} & cell_highest[k]);
            sel_window  = sel_window | ({WINDOW_BITS{hit_vec[k]}} & cell_window[k]);
        end
        sel_gt   = (req_reg.pkt_index > sel_highest);
        sel_dist = sel_gt ? (req_reg.pkt_index - sel_highest)
                          : (sel_highest - req_reg.pkt_index);
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= request;
        end
        if (state_reg == ST_SELECT)
        begin
            // the row and the key are unchanged since lookup
            miss_reg    <= !chain_hit[MAX_STREAMS];
            // the last cell drops off the row on a miss
            evict_reg   <= !chain_hit[MAX_STREAMS] && valid_vec[MAX_STREAMS-1];
            gt_reg      <= sel_gt;
            dist_reg    <= sel_dist;
            highest_reg <= sel_highest;
            window_reg  <= sel_window;
        end
    end

    // ------------------------------------------------------------------------
    // Update: start a new entry, or slide or mark the window, and form the verdict.
    // ------------------------------------------------------------------------
    assign far      = (dist_reg >= pswf_pkg::IDX_W'(WINDOW_BITS));
    assign shamt    = dist_reg[SHIFT_W-1:0];
    assign bit_mask = WINDOW_BITS'(1) << shamt;

    always_comb
    begin
        highest_next = highest_reg;
        window_next  = window_reg;
        verdict_next = pswf_pkg::VERDICT_FRESH;
        if (miss_reg)
        begin
            // new stream: take its first packet
            highest_next = req_reg.pkt_index;
            window_next  = WINDOW_BITS'(1);
        end
        else if (gt_reg)
        begin
            // advance: slide the window, clear it on a long jump
            highest_next = req_reg.pkt_index;
            window_next  = (far ? '0 : (window_reg << shamt)) | WINDOW_BITS'(1);
        end
        else if (far)
        begin
            verdict_next = pswf_pkg::VERDICT_OLD;
        end
        else if (|(window_reg & bit_mask))
        begin
            verdict_next = pswf_pkg::VERDICT_DUP;
        end
        else
        begin
            window_next = window_reg | bit_mask;
        end
    end

    // ------------------------------------------------------------------------
    // Sequencer and registered result
    // ------------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: state_next = ST_SELECT;
            ST_SELECT: state_next = ST_UPDATE;
            ST_UPDATE: state_next = accept ? ST_LOOKUP : ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_UPDATE);
            if (state_reg == ST_UPDATE)
            begin
                result_reg.verdict <= verdict_next;
                result_reg.evicted <= evict_reg;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    // a stream id lives in at most one cell
    a_single_hit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(hit_vec))
        else $error("more than one cell hit");

    // occupied cells form an unbroken run from the front of the row
    a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot({1'b0, valid_vec} + (MAX_STREAMS + 1)'(1)))
        else $error("empty cell in front of an occupied cell");

    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_UPDATE))
        else $error("result strobe without a write-back");

    a_evict_is_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.evicted) |-> (result.verdict == pswf_pkg::VERDICT_FRESH))
        else $error("eviction with a rejecting verdict");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");
`endif

endmodule

// ===== rtl/pswf_cell.sv =====
// ============================================================================
// pswf_cell - one entry of the recency-ordered stream table
// Holds a stream id, its highest index and seen-window. Compares against
// the broadcast key, then on update takes its neighbor's entry unless the hit
// lies in front of this cell, so the table stays in most-recent-first order.
// ============================================================================
module pswf_cell #(
    parameter int unsigned WINDOW_BITS = pswf_pkg::WINDOW_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pswf_pkg::cell_cmd_t         cmd,
    input  logic [pswf_pkg::SID_W-1:0]  key,
    input  logic                        chain_hit_in,
    output logic                        chain_hit_out,
    input  logic                        prev_valid,
    input  logic [pswf_pkg::SID_W-1:0]  prev_sid,
    input  logic [pswf_pkg::IDX_W-1:0]  prev_highest,
    input  logic [WINDOW_BITS-1:0]      prev_window,
    output logic                        valid,
    output logic [pswf_pkg::SID_W-1:0]  sid,
    output logic [pswf_pkg::IDX_W-1:0]  highest,
    output logic [WINDOW_BITS-1:0]      window,
    output logic                        hit
);

    logic                       valid_reg;
    logic                       hit_reg;
    logic                       move_reg;
    logic [pswf_pkg::SID_W-1:0] sid_reg;
    logic [pswf_pkg::IDX_W-1:0] highest_reg;
    logic [WINDOW_BITS-1:0]     window_reg;
    logic                       match;

    assign match         = valid_reg && (sid_reg == key);
    assign chain_hit_out = chain_hit_in | match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
            move_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.compare)
            begin
                hit_reg  <= match;
                // advance only if no hit sits in front of this cell
                move_reg <= !chain_hit_in;
            end
            if (cmd.update && move_reg)
            begin
                valid_reg <= prev_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update && move_reg)
        begin
            sid_reg     <= prev_sid;
            highest_reg <= prev_highest;
            window_reg  <= prev_window;
        end
    end

    assign valid   = valid_reg;
    assign sid     = sid_reg;
    assign highest = highest_reg;
    assign window  = window_reg;
    assign hit     = hit_reg;

endmodule

// ===== tb/pswf_verdict_checker.sv =====
// ============================================================================
// pswf_verdict_checker - verdict predictor and comparator for the filter
// Watches the request and result channels of the replay window filter,
// keeps its own stream table and works out the verdict for every accepted
// transaction, then compares each result strobe against the oldest one.
// ============================================================================
module pswf_verdict_checker
    import pswf_pkg::*;
#(
    parameter int unsigned NSTREAM = MAX_STREAMS_DEF,
    parameter int unsigned WIN     = WINDOW_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic busy,
    input  req_t request,
    input  logic done,
    input  rsp_t result,
    output int   mismatches,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [SID_W-1:0] tbl_sid   [NSTREAM];
    logic             tbl_live  [NSTREAM];
    logic [63:0]      tbl_stamp [NSTREAM];
    logic [IDX_W-1:0] tbl_top   [NSTREAM];
    logic [WIN-1:0]   tbl_seen  [NSTREAM];
    logic [63:0]      use_clock;

    rsp_t verdict_queue[$];
    int   fault_count;

    assign mismatches = fault_count;

    // Find, take or evict a table entry, then judge the index against it.
    function automatic rsp_t judge_packet(input req_t pkt);
        int unsigned      slot;
        int unsigned      lru;
        bit               found;
        bit               have_free;
        logic [IDX_W-1:0] gap;
        rsp_t             rsp;
        slot = 0;
        lru = 0;
        found = 1'b0;
        have_free = 1'b0;
        rsp.verdict = VERDICT_FRESH;
        rsp.evicted = 1'b0;
        for (int i = 0; i < NSTREAM; i++)
        begin
            if (!found)
            begin
                if (tbl_live[i] && tbl_sid[i] == pkt.stream_id)
                begin
                    slot = i;
                    found = 1'b1;
                end
                else
                begin
                    if (!tbl_live[i] && !have_free)
                    begin
                        have_free = 1'b1;
                        slot = i;
                    end
                    if (tbl_stamp[i] < tbl_stamp[lru])
                        lru = i;
                end
            end
        end

        use_clock = use_clock + 64'd1;
        if (!found)
        begin
            if (!have_free)
            begin
                slot = lru;
                rsp.evicted = 1'b1;
            end
            tbl_sid[slot]  = pkt.stream_id;
            tbl_live[slot] = 1'b1;
            tbl_top[slot]  = pkt.pkt_index;
            tbl_seen[slot] = '0;
            tbl_seen[slot][0] = 1'b1;
        end
        else if (pkt.pkt_index > tbl_top[slot])
        begin
            gap = pkt.pkt_index - tbl_top[slot];
            if (gap >= WIN)
                tbl_seen[slot] = '0;
            else
                tbl_seen[slot] = tbl_seen[slot] << gap;
            tbl_seen[slot][0] = 1'b1;
            tbl_top[slot] = pkt.pkt_index;
        end
        else
        begin
            gap = tbl_top[slot] - pkt.pkt_index;
            if (gap >= WIN)
                rsp.verdict = VERDICT_OLD;
            else if (tbl_seen[slot][gap])
                rsp.verdict = VERDICT_DUP;
            else
                tbl_seen[slot][gap] = 1'b1;
        end
        // refresh the stamp whatever the verdict
        tbl_stamp[slot] = use_clock;
        return rsp;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NSTREAM; i++)
            begin
                tbl_sid[i]   = '0;
                tbl_live[i]  = 1'b0;
                tbl_stamp[i] = '0;
                tbl_top[i]   = '0;
                tbl_seen[i]  = '0;
            end
            use_clock = '0;
            verdict_queue.delete();
            fault_count = 0;
            outstanding <= 0;
        end
        else
        begin
            // compare first: a result at this edge belongs to an older transaction
            if (done)
            begin
                if (verdict_queue.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= 10)
                        $display("%0t: result with no transaction waiting: verdict %0d evicted %0b",
                                 $realtime, result.verdict, result.evicted);
                end
                else
                begin
                    want = verdict_queue.pop_front();
                    if (result.verdict !== want.verdict || result.evicted !== want.evicted)
                    begin
                        fault_count++;
                        if (fault_count <= 10)
                            $display("%0t: verdict exp %0d got %0d, evicted exp %0b got %0b",
                                     $realtime, want.verdict, result.verdict,
                                     want.evicted, result.evicted);
                    end
                end
            end
            if (start && !busy)
                verdict_queue.push_back(judge_packet(request));
            outstanding <= verdict_queue.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// ============================================================================
// tb_top - testbench for the per-stream replay window filter
// Drives packets through the command interface: a directed run over window
// edges, eviction and recency, then random packets from a pool of streams
// that outnumbers the table. The checker predicts and compares every verdict.
// ============================================================================
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pswf_pkg::*;

    localparam int          POOL        = 12;
    localparam int          RAND_ITEMS  = 1800;
    localparam int          CALM_ITEMS  = 200;   // tail of the run without idling
    localparam int unsigned CYCLE_LIMIT = 200000;

    logic clk;
    logic rst_n;
    logic start;
    req_t request;
    logic busy;
    logic done;
    rsp_t result;
    int   mismatches;
    int   outstanding;

    int unsigned cycle_count = 0;

    // stream pool for the random part: ids and the highest index sent so far
    logic [SID_W-1:0] pool_sid [POOL];
    logic [IDX_W-1:0] pool_top [POOL];

    per_stream_replay_window_filter_top dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    pswf_verdict_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .request     (request),
        .done        (done),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Guard the whole run; a hung handshake lands here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Present one transaction and hold it until the filter takes it.
    // start stays high on return so back-to-back packets follow without start being raised again.
    task automatic offer_packet(input logic [SID_W-1:0] sid, input logic [IDX_W-1:0] idx);
        request <= '{stream_id: sid, pkt_index: idx};
        start   <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Send one packet, then idle a random burst with the given percentage.
    task automatic send_packet(input logic [SID_W-1:0] sid, input logic [IDX_W-1:0] idx,
                               input int idle_pct);
        offer_packet(sid, idx);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Pick an index near the stream's front, sometimes far off or fully random.
    function automatic logic [IDX_W-1:0] pick_index(input logic [IDX_W-1:0] front);
        logic [IDX_W-1:0] idx;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: idx = front - IDX_W'($urandom_range(0, 140));
            4, 5, 6:    idx = front + IDX_W'($urandom_range(1, 8));
            7:          idx = front + IDX_W'($urandom_range(60, 200));
            8:          idx = front - IDX_W'($urandom_range(0, 3));
            default:    idx = IDX_W'({$urandom, $urandom});
        endcase
        return idx;
    endfunction

    initial
    begin
        int               slot;
        int               idle_pct;
        logic [SID_W-1:0] sid;
        logic [IDX_W-1:0] idx;

        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: window edges on the all-zero stream id
        send_packet(32'h0000_0000, 48'd0,   30);    // new entry, accepted
        send_packet(32'h0000_0000, 48'd0,   30);    // equal to highest: duplicate
        send_packet(32'h0000_0000, 48'd127, 30);    // advance by one less than the window
        send_packet(32'h0000_0000, 48'd0,   30);    // oldest slot still in the window
        send_packet(32'h0000_0000, 48'd255, 30);    // jump of a full window clears it
        send_packet(32'h0000_0000, 48'd127, 30);    // just past the window: too old
        send_packet(32'h0000_0000, 48'd191, 30);    // upper half of the window, fresh
        send_packet(32'h0000_0000, 48'd191, 30);    // same again: duplicate
        // all-ones stream id at the top of the index range
        send_packet(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 30);
        send_packet(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFE, 30);
        send_packet(32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 30);
        send_packet(32'hFFFF_FFFF, 48'd0, 30);      // far below: too old
        // fill the rest of the table
        for (int k = 0; k < 6; k++)
            send_packet(32'h1 << (k * 5), 48'h8000_0000_0000 + 48'(k), 30);
        // a rejected packet still refreshes the all-zero stream
        send_packet(32'h0000_0000, 48'd0, 30);
        // table full: evict the least recent, which is the all-ones stream
        send_packet(32'hA5A5_5A5A, 48'h5555_5555_5555, 30);
        send_packet(32'hFFFF_FFFF, 48'h1234_5678_9ABC, 30);
        // the all-zero stream survived both evictions
        send_packet(32'h0000_0000, 48'd255, 30);

        // --- random: a pool larger than the table keeps evictions coming
        for (int k = 0; k < POOL; k++)
        begin
            pool_sid[k] = $urandom;
            pool_top[k] = IDX_W'({$urandom, $urandom});
        end
        pool_top[0] = 48'd64;
        pool_top[1] = 48'hFFFF_FFFF_FFC0;

        idle_pct = 0;
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            // vary idling per stretch, including stretches with none
            if (n % 100 == 0)
                idle_pct = ($urandom_range(0, 2)) * 25;
            if (n >= RAND_ITEMS - CALM_ITEMS)
                idle_pct = 0;

            // mostly hit a working set that fits the table, sometimes the rest
            if ($urandom_range(0, 9) < 8)
                slot = $urandom_range(0, 6);
            else
                slot = $urandom_range(7, POOL - 1);

            if ($urandom_range(0, 19) == 0)
                sid = $urandom;             // stray stream, forces a table miss
            else
                sid = pool_sid[slot];
            idx = pick_index(pool_top[slot]);
            if (sid == pool_sid[slot] && idx > pool_top[slot])
                pool_top[slot] = idx;
            send_packet(sid, idx, idle_pct);
        end
        start <= 1'b0;

        // drain: wait for every verdict, then let the pipeline settle
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
